FILE: sv/rv3_pkg.sv
// shared constants, types and the arc tangent table for the 3d axis rotator
package rv3_pkg;

	// default configuration
	localparam int COORD_WIDTH_DEF     = 32;
	localparam int ANGLE_WIDTH_DEF     = 16;
	localparam int ROTATION_STAGES_DEF = 16;

	// cordic vector: q2.30 carried in a few guard bits
	localparam int VEC_FRAC = 30;
	localparam int VEC_W    = 34;

	localparam logic signed [VEC_W-1:0] CORDIC_GAIN = VEC_W'(652032874);

	// axis codes
	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_sel_t;

	// fraction bits of the rounded cos and sin
	function automatic int trig_frac(input int cw);
		trig_frac = ((62 - cw) < VEC_FRAC) ? (62 - cw) : VEC_FRAC;
	endfunction

	// atan(2^-i) in 2^-32 turn units
	function automatic logic signed [VEC_W-1:0] arc_entry(input int i);
		logic signed [VEC_W-1:0] v;
		case (i)
			0:       v = VEC_W'(536870912);
			1:       v = VEC_W'(316933406);
			2:       v = VEC_W'(167458907);
			3:       v = VEC_W'(85004756);
			4:       v = VEC_W'(42667331);
			5:       v = VEC_W'(21354465);
			6:       v = VEC_W'(10679838);
			7:       v = VEC_W'(5340245);
			8:       v = VEC_W'(2670163);
			9:       v = VEC_W'(1335087);
			10:      v = VEC_W'(667544);
			11:      v = VEC_W'(333772);
			12:      v = VEC_W'(166886);
			13:      v = VEC_W'(83443);
			14:      v = VEC_W'(41722);
			15:      v = VEC_W'(20861);
			16:      v = VEC_W'(10430);
			17:      v = VEC_W'(5215);
			18:      v = VEC_W'(2608);
			19:      v = VEC_W'(1304);
			20:      v = VEC_W'(652);
			21:      v = VEC_W'(326);
			22:      v = VEC_W'(163);
			23:      v = VEC_W'(81);
			24:      v = VEC_W'(41);
			25:      v = VEC_W'(20);
			26:      v = VEC_W'(10);
			27:      v = VEC_W'(5);
			28:      v = VEC_W'(3);
			29:      v = VEC_W'(1);
			30:      v = VEC_W'(1);
			default: v = '0;
		endcase
		arc_entry = v;
	endfunction

endpackage

FILE: sv/rv3_cordic_cell.sv
// one cordic micro-rotation cell, registered, with the point riding alongside
module rv3_cordic_cell #(
	parameter int STAGE  = 0,
	parameter int PASS_W = 98
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              up_valid,
	input  logic signed [rv3_pkg::VEC_W-1:0]  up_x,
	input  logic signed [rv3_pkg::VEC_W-1:0]  up_y,
	input  logic signed [rv3_pkg::VEC_W-1:0]  up_z,
	input  logic [PASS_W-1:0]                 up_data,
	output logic                              dn_valid,
	output logic signed [rv3_pkg::VEC_W-1:0]  dn_x,
	output logic signed [rv3_pkg::VEC_W-1:0]  dn_y,
	output logic signed [rv3_pkg::VEC_W-1:0]  dn_z,
	output logic [PASS_W-1:0]                 dn_data
);
	import rv3_pkg::*;

	localparam logic signed [VEC_W-1:0] ARC = arc_entry(STAGE);

	logic                    valid_s1;
	logic signed [VEC_W-1:0] x_s1, y_s1, z_s1;
	logic [PASS_W-1:0]       data_s1;
	logic signed [VEC_W-1:0] x_sh, y_sh, x_nxt, y_nxt, z_nxt;

	assign x_sh = up_x >>> STAGE;
	assign y_sh = up_y >>> STAGE;

	// rotate toward zero residual
	always_comb begin
		if (!up_z[VEC_W-1]) begin
			x_nxt = up_x - y_sh;
			y_nxt = up_y + x_sh;
			z_nxt = up_z - ARC;
		end else begin
			x_nxt = up_x + y_sh;
			y_nxt = up_y - x_sh;
			z_nxt = up_z + ARC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= x_nxt;
			y_s1    <= y_nxt;
			z_s1    <= z_nxt;
			data_s1 <= up_data;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_x     = x_s1;
	assign dn_y     = y_s1;
	assign dn_z     = z_s1;
	assign dn_data  = data_s1;

endmodule

FILE: sv/rv3_pair_rotate.sv
// rounds cos/sin, multiplies the coordinate pair, sums, rounds and saturates
module rv3_pair_rotate #(
	parameter int COORD_WIDTH = rv3_pkg::COORD_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              up_valid,
	input  logic signed [rv3_pkg::VEC_W-1:0]  cos_raw,
	input  logic signed [rv3_pkg::VEC_W-1:0]  sin_raw,
	input  logic [3*COORD_WIDTH+1:0]          up_data,
	output logic                              out_valid,
	output logic signed [COORD_WIDTH-1:0]     rot_x,
	output logic signed [COORD_WIDTH-1:0]     rot_y,
	output logic signed [COORD_WIDTH-1:0]     rot_z
);
	import rv3_pkg::*;

	localparam int TF    = trig_frac(COORD_WIDTH);
	localparam int TSH   = VEC_FRAC - TF;
	localparam int CTW   = TF + 3;
	localparam int PRD_W = COORD_WIDTH + CTW;
	localparam int SUM_W = PRD_W + 2;
	localparam int CW    = COORD_WIDTH;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (TF - 1);
	localparam logic signed [SUM_W-1:0] HI   =
		{{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] LO   = ~HI;

	axis_sel_t               axis_in;
	logic signed [CW-1:0]    px, py, pz;
	logic signed [VEC_W-1:0] cos_rnd, sin_rnd;

	assign axis_in = axis_sel_t'(up_data[3*CW+1:3*CW]);
	assign px      = up_data[3*CW-1:2*CW];
	assign py      = up_data[2*CW-1:CW];
	assign pz      = up_data[CW-1:0];

	// round half up from 30 fraction bits to TF
	generate
		if (TSH == 0) begin : g_no_round
			assign cos_rnd = cos_raw;
			assign sin_rnd = sin_raw;
		end else begin : g_round
			localparam logic signed [VEC_W-1:0] TRND = VEC_W'(1) <<< (TSH - 1);
			assign cos_rnd = (cos_raw + TRND) >>> TSH;
			assign sin_rnd = (sin_raw + TRND) >>> TSH;
		end
	endgenerate

	// stage 1: trig values and pair selection
	logic                  valid_s1;
	axis_sel_t             axis_s1;
	logic signed [CTW-1:0] c_s1, s_s1;
	logic signed [CW-1:0]  f_s1, g_s1, cx_s1, cy_s1, cz_s1;

	// stage 2: products
	logic                    valid_s2;
	axis_sel_t               axis_s2;
	logic signed [PRD_W-1:0] fc_s2, gs_s2, gc_s2, fs_s2;
	logic signed [CW-1:0]    cx_s2, cy_s2, cz_s2;

	// stage 3: output register
	logic                 valid_s3;
	logic signed [CW-1:0] rx_s3, ry_s3, rz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= up_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axis_s1 <= axis_in;
			c_s1    <= cos_rnd[CTW-1:0];
			s_s1    <= sin_rnd[CTW-1:0];
			f_s1    <= (axis_in == AXIS_X) ? py : px;
			g_s1    <= (axis_in == AXIS_Z) ? py : pz;
			cx_s1   <= px;
			cy_s1   <= py;
			cz_s1   <= pz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axis_s2 <= axis_s1;
			fc_s2   <= f_s1 * c_s1;
			gs_s2   <= g_s1 * s_s1;
			gc_s2   <= g_s1 * c_s1;
			fs_s2   <= f_s1 * s_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			cz_s2   <= cz_s1;
		end
	end

	logic signed [SUM_W-1:0] first_sum, second_sum, first_shr, second_shr;
	logic signed [CW-1:0]    first_sat, second_sat;

	assign first_sum  = SUM_W'(fc_s2) - SUM_W'(gs_s2) + HALF;
	assign second_sum = SUM_W'(gc_s2) + SUM_W'(fs_s2) + HALF;
	assign first_shr  = first_sum >>> TF;
	assign second_shr = second_sum >>> TF;

	always_comb begin
		if (first_shr > HI) begin
			first_sat = HI[CW-1:0];
		end else if (first_shr < LO) begin
			first_sat = LO[CW-1:0];
		end else begin
			first_sat = first_shr[CW-1:0];
		end
		if (second_shr > HI) begin
			second_sat = HI[CW-1:0];
		end else if (second_shr < LO) begin
			second_sat = LO[CW-1:0];
		end else begin
			second_sat = second_shr[CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (axis_s2)
				AXIS_X: begin
					rx_s3 <= cx_s2;
					ry_s3 <= first_sat;
					rz_s3 <= second_sat;
				end
				AXIS_Y: begin
					rx_s3 <= first_sat;
					ry_s3 <= cy_s2;
					rz_s3 <= second_sat;
				end
				AXIS_Z: begin
					rx_s3 <= first_sat;
					ry_s3 <= second_sat;
					rz_s3 <= cz_s2;
				end
				default: begin
					rx_s3 <= cx_s2;
					ry_s3 <= cy_s2;
					rz_s3 <= cz_s2;
				end
			endcase
		end
	end

	assign out_valid = valid_s3;
	assign rot_x     = rx_s3;
	assign rot_y     = ry_s3;
	assign rot_z     = rz_s3;

	// no-rotation items leave the point untouched
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s2 && axis_s2 == AXIS_NONE |=>
			rot_x == $past(cx_s2) && rot_y == $past(cy_s2) && rot_z == $past(cz_s2))
		else $error("pass-through point altered");

endmodule

FILE: sv/axis_rotate_vector3.sv
// throughput: one point per cycle while the output is not stalled; an angle prep register
// feeds a row of cordic cells, one cell per micro-rotation, then select, multiply and
// round/saturate stages
// an output stall while out_valid is high freezes the whole pipeline and raises in_stall
// reset: arst_n clears all valid bits asynchronously; data registers are not reset
// top level: angle prep, cordic cell chain and pair rotation
module axis_rotate_vector3 #(
	parameter int COORD_WIDTH     = rv3_pkg::COORD_WIDTH_DEF,
	parameter int ANGLE_WIDTH     = rv3_pkg::ANGLE_WIDTH_DEF,
	parameter int ROTATION_STAGES = rv3_pkg::ROTATION_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	input  logic [1:0]                    axis_select,
	input  logic [ANGLE_WIDTH-1:0]        turn_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] rot_x,
	output logic signed [COORD_WIDTH-1:0] rot_y,
	output logic signed [COORD_WIDTH-1:0] rot_z
);
	import rv3_pkg::*;

	localparam int PASS_W = 3 * COORD_WIDTH + 2;

	logic adv;

	// everything moves together unless the output is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	// angle prep: fold into the right half plane, negating the start vector
	logic [31:0]             turn32, turn_fold;
	logic                    fold;
	logic signed [VEC_W-1:0] x_start, z_start;

	assign turn32    = {turn_angle, {(32-ANGLE_WIDTH){1'b0}}};
	assign fold      = turn32[31] ^ turn32[30];
	assign turn_fold = {turn32[31] ^ fold, turn32[30:0]};
	assign x_start   = fold ? -CORDIC_GAIN : CORDIC_GAIN;
	assign z_start   = VEC_W'(signed'(turn_fold));

	logic                    valid_s0;
	logic signed [VEC_W-1:0] x_s0, z_s0;
	logic [PASS_W-1:0]       data_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (adv) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s0    <= x_start;
			z_s0    <= z_start;
			data_s0 <= {axis_select, coord_x, coord_y, coord_z};
		end
	end

	// cordic cell chain
	logic                    ch_valid [0:ROTATION_STAGES];
	logic signed [VEC_W-1:0] ch_x     [0:ROTATION_STAGES];
	logic signed [VEC_W-1:0] ch_y     [0:ROTATION_STAGES];
	logic signed [VEC_W-1:0] ch_z     [0:ROTATION_STAGES];
	logic [PASS_W-1:0]       ch_data  [0:ROTATION_STAGES];
	logic [ROTATION_STAGES:0] valid_line;

	assign ch_valid[0] = valid_s0;
	assign ch_x[0]     = x_s0;
	assign ch_y[0]     = '0;
	assign ch_z[0]     = z_s0;
	assign ch_data[0]  = data_s0;

	generate
		for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
			rv3_cordic_cell #(
				.STAGE  (g),
				.PASS_W (PASS_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.en       (adv),
				.up_valid (ch_valid[g]),
				.up_x     (ch_x[g]),
				.up_y     (ch_y[g]),
				.up_z     (ch_z[g]),
				.up_data  (ch_data[g]),
				.dn_valid (ch_valid[g+1]),
				.dn_x     (ch_x[g+1]),
				.dn_y     (ch_y[g+1]),
				.dn_z     (ch_z[g+1]),
				.dn_data  (ch_data[g+1])
			);
		end
		for (genvar v = 0; v <= ROTATION_STAGES; v++) begin : g_vline
			assign valid_line[v] = ch_valid[v];
		end
	endgenerate

	rv3_pair_rotate #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_pair (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.up_valid  (ch_valid[ROTATION_STAGES]),
		.cos_raw   (ch_x[ROTATION_STAGES]),
		.sin_raw   (ch_y[ROTATION_STAGES]),
		.up_data   (ch_data[ROTATION_STAGES]),
		.out_valid (out_valid),
		.rot_x     (rot_x),
		.rot_y     (rot_y),
		.rot_z     (rot_z)
	);

	a_reset_clear: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s0)
		else $error("accepted transfer not captured");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(valid_line))
		else $error("cell chain moved while output held");

endmodule

FILE: bench/rotation_checker.sv
`timescale 1ns / 100ps
// scoreboard for the axis rotator: predicts each rotated point and compares the output stream
module rotation_checker (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	input  logic                                       in_stall,
	input  logic signed [rv3_pkg::COORD_WIDTH_DEF-1:0] coord_x,
	input  logic signed [rv3_pkg::COORD_WIDTH_DEF-1:0] coord_y,
	input  logic signed [rv3_pkg::COORD_WIDTH_DEF-1:0] coord_z,
	input  logic [1:0]                                 axis_select,
	input  logic [rv3_pkg::ANGLE_WIDTH_DEF-1:0]        turn_angle,
	input  logic                                       out_valid,
	input  logic                                       out_stall,
	input  logic signed [rv3_pkg::COORD_WIDTH_DEF-1:0] rot_x,
	input  logic signed [rv3_pkg::COORD_WIDTH_DEF-1:0] rot_y,
	input  logic signed [rv3_pkg::COORD_WIDTH_DEF-1:0] rot_z,
	output int                                         fail_count,
	output int                                         pending
);
	import rv3_pkg::*;

	localparam int CW        = COORD_WIDTH_DEF;
	localparam int AW        = ANGLE_WIDTH_DEF;
	localparam int STAGES    = ROTATION_STAGES_DEF;
	localparam int TRIG_BITS = ((62 - CW) < VEC_FRAC) ? (62 - CW) : VEC_FRAC;
	localparam longint UNIT_GAIN = 64'sd652032874;
	localparam longint COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	point_t rotated_points[$];
	point_t want;
	point_t seen;

	// micro-rotation angles, atan(2^-i) in 2^-32 turn units
	function automatic longint atan_turn(input int i);
		case (i)
			0:  return 536870912;
			1:  return 316933406;
			2:  return 167458907;
			3:  return 85004756;
			4:  return 42667331;
			5:  return 21354465;
			6:  return 10679838;
			7:  return 5340245;
			8:  return 2670163;
			9:  return 1335087;
			10: return 667544;
			11: return 333772;
			12: return 166886;
			13: return 83443;
			14: return 41722;
			15: return 20861;
			16: return 10430;
			17: return 5215;
			18: return 2608;
			19: return 1304;
			20: return 652;
			21: return 326;
			22: return 163;
			23: return 81;
			24: return 41;
			25: return 20;
			26: return 10;
			27: return 5;
			28: return 3;
			29: return 1;
			30: return 1;
			default: return 0;
		endcase
	endfunction

	// round half up, then drop n fraction bits
	function automatic longint round_shr(input longint v, input int n);
		if (n == 0)
			return v;
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [CW-1:0] clamp_coord(input longint v);
		if (v > COORD_MAX)
			return COORD_MAX[CW-1:0];
		if (v < COORD_MIN)
			return COORD_MIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic void rotate_pair(inout longint a, inout longint b,
			input longint c, input longint s);
		longint f;
		longint g;
		f = a;
		g = b;
		a = round_shr(f * c - g * s, TRIG_BITS);
		b = round_shr(g * c + f * s, TRIG_BITS);
	endfunction

	function automatic point_t rotate_point(input logic signed [CW-1:0] px,
			input logic signed [CW-1:0] py, input logic signed [CW-1:0] pz,
			input logic [1:0] sel, input logic [AW-1:0] ang);
		logic [31:0] turn;
		longint vx;
		longint vy;
		longint nx;
		longint resid;
		longint c;
		longint s;
		longint x;
		longint y;
		longint z;
		axis_sel_t axis;
		point_t p;
		x = px;
		y = py;
		z = pz;
		axis = axis_sel_t'(sel);
		if (axis != AXIS_NONE) begin
			turn = 32'(ang) << (32 - AW);
			vx = UNIT_GAIN;
			vy = 0;
			// second and third quadrant: fold by half a turn, flip the start vector
			if (turn[31:30] == 2'b01 || turn[31:30] == 2'b10) begin
				turn = turn - 32'h8000_0000;
				vx = -vx;
			end
			resid = $signed(turn);
			for (int i = 0; i < STAGES; i++) begin
				if (resid >= 0) begin
					nx = vx - (vy >>> (i % 32));
					vy = vy + (vx >>> (i % 32));
					resid = resid - atan_turn(i % 32);
				end else begin
					nx = vx + (vy >>> (i % 32));
					vy = vy - (vx >>> (i % 32));
					resid = resid + atan_turn(i % 32);
				end
				vx = nx;
			end
			c = round_shr(vx, VEC_FRAC - TRIG_BITS);
			s = round_shr(vy, VEC_FRAC - TRIG_BITS);
			case (axis)
				AXIS_X:  rotate_pair(y, z, c, s);
				AXIS_Y:  rotate_pair(x, z, c, s);
				default: rotate_pair(x, y, c, s);
			endcase
		end
		p.x = clamp_coord(x);
		p.y = clamp_coord(y);
		p.z = clamp_coord(z);
		return p;
	endfunction

	task automatic compare_field(input string name, input logic signed [CW-1:0] exp_v,
			input logic signed [CW-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			fail_count = 0;
			rotated_points.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				rotated_points.push_back(rotate_point(coord_x, coord_y, coord_z,
					axis_select, turn_angle));
			if (out_valid && !out_stall) begin
				seen.x = rot_x;
				seen.y = rot_y;
				seen.z = rot_z;
				if (rotated_points.size() == 0) begin
					$display("%0t: unexpected output transfer, expected none, got (%0d, %0d, %0d)",
						$time, seen.x, seen.y, seen.z);
					fail_count++;
				end else begin
					want = rotated_points.pop_front();
					compare_field("rot_x", want.x, seen.x);
					compare_field("rot_y", want.y, seen.y);
					compare_field("rot_z", want.z, seen.z);
				end
			end
			pending <= rotated_points.size();
		end
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// stimulus and verdict for the 3d axis rotator, checking done by rotation_checker
module tb;
	import rv3_pkg::*;

	localparam int CW         = COORD_WIDTH_DEF;
	localparam int AW         = ANGLE_WIDTH_DEF;
	localparam int LATENCY    = ROTATION_STAGES_DEF + 4;
	localparam int CYCLE_CAP  = 200000;
	localparam int PHASES     = 5;
	localparam int PHASE_LEN  = 150;

	localparam logic signed [CW-1:0] C_MAX = 32'sh7fff_ffff;
	localparam logic signed [CW-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [CW-1:0] ONE   = 32'sh0001_0000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [CW-1:0] coord_x;
	logic signed [CW-1:0] coord_y;
	logic signed [CW-1:0] coord_z;
	logic [1:0]           axis_select;
	logic [AW-1:0]        turn_angle;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [CW-1:0] rot_x;
	logic signed [CW-1:0] rot_y;
	logic signed [CW-1:0] rot_z;
	int                   fail_count;
	int                   pending;
	int                   cycle_count = 0;
	bit                   steady;

	axis_rotate_vector3 i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.axis_select (axis_select),
		.turn_angle  (turn_angle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rot_x       (rot_x),
		.rot_y       (rot_y),
		.rot_z       (rot_z)
	);

	rotation_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.axis_select (axis_select),
		.turn_angle  (turn_angle),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.rot_x       (rot_x),
		.rot_y       (rot_y),
		.rot_z       (rot_z),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int idle_len();
		if (steady)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// full range, a few hundred units, or a few units around zero
	function automatic logic signed [CW-1:0] random_coord(input int span);
		case (span)
			0:       return $urandom;
			1:       return 32'($urandom_range(0, 33554431)) - 32'sd16777216;
			default: return 32'($urandom_range(0, 1048575)) - 32'sd524288;
		endcase
	endfunction

	task automatic drive_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
			input logic signed [CW-1:0] z, input axis_sel_t axis, input logic [AW-1:0] ang);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		coord_x     <= x;
		coord_y     <= y;
		coord_z     <= z;
		axis_select <= axis;
		turn_angle  <= ang;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_points();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// output side: random back-pressure per transfer
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = idle_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		logic [AW-1:0] ang;
		axis_sel_t axis;
		int span;
		steady = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		coord_x <= '0;
		coord_y <= '0;
		coord_z <= '0;
		axis_select <= AXIS_NONE;
		turn_angle <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pass-through, quadrant edges, exact turns and saturation
		drive_point(C_MAX, C_MIN, -1, AXIS_NONE, 16'hffff);
		drive_point(C_MIN, C_MAX, 0, AXIS_NONE, 16'h1234);
		drive_point(0, ONE, 2 * ONE, AXIS_X, 16'h0000);
		drive_point(0, ONE, ONE, AXIS_X, 16'h4000);
		drive_point(ONE, 0, -ONE, AXIS_Y, 16'h8000);
		drive_point(ONE, ONE, 5, AXIS_Z, 16'hc000);
		drive_point(C_MAX, C_MIN, 0, AXIS_Z, 16'hffff);
		drive_point(C_MAX, C_MAX, 0, AXIS_Z, 16'h2000);
		drive_point(C_MIN, C_MIN, 0, AXIS_Z, 16'h2000);
		drive_point(0, C_MAX, C_MAX, AXIS_X, 16'h2000);
		drive_point(C_MAX, 0, C_MAX, AXIS_Y, 16'h6000);
		drive_point(3 * ONE, -1, -7 * ONE, AXIS_Y, 16'h3fff);
		drive_point(3 * ONE, -1, -7 * ONE, AXIS_Y, 16'h4000);
		drive_point(3 * ONE, -1, -7 * ONE, AXIS_Y, 16'hbfff);
		drive_point(3 * ONE, -1, -7 * ONE, AXIS_Y, 16'hc000);
		drive_point(7, C_MAX, C_MIN, AXIS_X, 16'h7fff);
		drive_point(7, C_MAX, C_MIN, AXIS_X, 16'h8000);
		drive_point(C_MIN, C_MAX, -1, AXIS_Z, 16'h0000);
		drive_point(-ONE, C_MIN, C_MAX, AXIS_Y, 16'h0001);
		drain_points();

		for (int ph = 0; ph < PHASES; ph++) begin
			steady = (ph == 1);
			for (int k = 0; k < PHASE_LEN; k++) begin
				axis = axis_sel_t'(2'($urandom_range(0, 3)));
				if ($urandom_range(0, 7) == 0)
					ang = AW'(($urandom_range(0, 3) << (AW - 2)) + $urandom_range(0, 2) - 1);
				else
					ang = AW'($urandom_range(0, (1 << AW) - 1));
				span = $urandom_range(0, 2);
				drive_point(random_coord(span), random_coord(span), random_coord(span),
					axis, ang);
			end
			// hold off until the pipeline is empty
			drain_points();
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
